FILE: sv/heightmap_altitude_sampler_top_assert.svh
// Assertion macros shared by the checker of the altitude sampler.
`ifndef HEIGHTMAP_ALTITUDE_SAMPLER_TOP_ASSERT_SVH
`define HEIGHTMAP_ALTITUDE_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HMAS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HMAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: sv/hmas_pkg.sv
`timescale 1ns / 1ps

package hmas_pkg;

    localparam int GRID_CELLS_DEF = 16384;

    localparam int CFG_AW = 5;

    localparam logic [7:0]  RST_GRID_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_GRID_HEIGHT = 8'd128;
    localparam logic [31:0] RST_ORIGIN_X    = 32'd0;
    localparam logic [31:0] RST_ORIGIN_Y    = 32'd0;
    localparam logic [31:0] RST_CELL_SCALE  = 32'd65536;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_ORIGIN_X    = 3'd2,
        REG_ORIGIN_Y    = 3'd3,
        REG_CELL_SCALE  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  grid_width;
        logic [7:0]  grid_height;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] cell_scale;
    } t_cfg;

    // The three corners that carry weight: top left, the middle corner
    // (bottom left or top right, depending on the triangle) and bottom right.
    typedef enum logic [1:0] {
        C_LT  = 2'd0,
        C_MID = 2'd1,
        C_RB  = 2'd2
    } t_corner;

    typedef enum logic [3:0] {
        S_IDLE = 4'd0,
        S_MULX = 4'd1,
        S_MULY = 4'd2,
        S_CELL = 4'd3,
        S_IDX  = 4'd4,
        S_RD0  = 4'd5,
        S_RD1  = 4'd6,
        S_RD2  = 4'd7,
        S_MAC3 = 4'd8,
        S_MAC4 = 4'd9,
        S_FIN  = 4'd10
    } t_state;

    typedef struct packed {
        logic    w_en;
        logic    q_load;
        logic    mul_x;
        logic    mul_y;
        logic    cell_ld;
        logic    idx_ld;
        logic    rd_en;
        t_corner rd_sel;
        logic    mul_en;
        t_corner mul_sel;
        logic    acc_load;
        logic    acc_add;
        logic    out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: sv/hmas_ram.sv
`timescale 1ns / 1ps

module hmas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hmas_regs.sv
`timescale 1ns / 1ps

module hmas_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hmas_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output hmas_pkg::t_cfg                o_cfg
);

    import hmas_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= RST_GRID_WIDTH;
            r_cfg.grid_height <= RST_GRID_HEIGHT;
            r_cfg.origin_x    <= RST_ORIGIN_X;
            r_cfg.origin_y    <= RST_ORIGIN_Y;
            r_cfg.cell_scale  <= RST_CELL_SCALE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GRID_WIDTH:  r_cfg.grid_width  <= pwdata[7:0];
                REG_GRID_HEIGHT: r_cfg.grid_height <= pwdata[7:0];
                REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata;
                REG_ORIGIN_Y:    r_cfg.origin_y    <= pwdata;
                REG_CELL_SCALE:  r_cfg.cell_scale  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GRID_WIDTH:  prdata = 32'(r_cfg.grid_width);
            REG_GRID_HEIGHT: prdata = 32'(r_cfg.grid_height);
            REG_ORIGIN_X:    prdata = r_cfg.origin_x;
            REG_ORIGIN_Y:    prdata = r_cfg.origin_y;
            REG_CELL_SCALE:  prdata = r_cfg.cell_scale;
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/hmas_ctrl.sv
`timescale 1ns / 1ps

module hmas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_opcode,
    input  hmas_pkg::t_dp_stat  i_stat,
    output logic                o_ready,
    output hmas_pkg::t_dp_cmd   o_cmd
);

    import hmas_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_query;

    assign w_query = i_valid && (i_opcode == OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_CELL;
            S_CELL: n_state = S_IDX;
            S_IDX:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_MAC3;
            S_MAC3: n_state = S_MAC4;
            S_MAC4: n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.w_en   = i_valid && (i_opcode == OP_WRITE);
                o_cmd.q_load = w_query;
            end
            S_MULX: o_cmd.mul_x   = 1'b1;
            S_MULY: o_cmd.mul_y   = 1'b1;
            S_CELL: o_cmd.cell_ld = 1'b1;
            S_IDX:  o_cmd.idx_ld  = 1'b1;
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = C_LT;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = C_MID;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = C_LT;
            end
            S_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = C_RB;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = C_MID;
                o_cmd.acc_load = 1'b1;
            end
            S_MAC3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = C_RB;
                o_cmd.acc_add = 1'b1;
            end
            S_MAC4: o_cmd.acc_add = 1'b1;
            S_FIN:  o_cmd.out_ld  = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

FILE: sv/hmas_dp.sv
`timescale 1ns / 1ps

module hmas_dp #(
    parameter int GRID_CELLS = hmas_pkg::GRID_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hmas_pkg::t_cfg     i_cfg,
    input  hmas_pkg::t_dp_cmd  i_cmd,
    input  logic [13:0]        i_cell_index,
    input  logic [31:0]        i_cell_height,
    input  logic [31:0]        i_point_x,
    input  logic [31:0]        i_point_y,
    input  logic               i_ready,
    output hmas_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output logic [31:0]        o_altitude
);

    import hmas_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);
    // Index width: wide enough for any corner index and for the depth itself.
    localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam logic [CW-1:0] CELLS = CW'(GRID_CELLS);

    // Offsets from the origin, clamped at zero.
    logic [32:0] w_dx_s, w_dy_s;
    logic [31:0] r_dx, r_dy;

    assign w_dx_s = {i_point_x[31], i_point_x} - {i_cfg.origin_x[31], i_cfg.origin_x};
    assign w_dy_s = {i_point_y[31], i_point_y} - {i_cfg.origin_y[31], i_cfg.origin_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_dx <= w_dx_s[32] ? 32'd0 : w_dx_s[31:0];
            r_dy <= w_dy_s[32] ? 32'd0 : w_dy_s[31:0];
        end
    end

    // One shared scaling multiplier, x first and then y.
    logic [31:0] w_mul_a;
    logic [63:0] w_mul_p;
    logic [63:0] r_sx, r_sy;

    assign w_mul_a = i_cmd.mul_y ? r_dy : r_dx;
    assign w_mul_p = w_mul_a * i_cfg.cell_scale;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_x) begin
            r_sx <= w_mul_p;
        end
        if (i_cmd.mul_y) begin
            r_sy <= w_mul_p;
        end
    end

    // Cell and fraction, far neighbor clamped to the last column or row.
    logic [7:0]  w_w, w_h, w_wm1, w_hm1;
    logic        w_clx, w_cly;
    logic [7:0]  r_x0, r_x1, r_y0, r_y1, r_w;
    logic [15:0] r_fx, r_fy;

    assign w_w   = (i_cfg.grid_width == 8'd0) ? 8'd1 : i_cfg.grid_width;
    assign w_h   = (i_cfg.grid_height == 8'd0) ? 8'd1 : i_cfg.grid_height;
    assign w_wm1 = w_w - 8'd1;
    assign w_hm1 = w_h - 8'd1;
    assign w_clx = r_sx[63:32] >= {24'd0, w_wm1};
    assign w_cly = r_sy[63:32] >= {24'd0, w_hm1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_ld) begin
            r_x0 <= w_clx ? w_wm1 : r_sx[39:32];
            r_x1 <= w_clx ? w_wm1 : r_sx[39:32] + 8'd1;
            r_y0 <= w_cly ? w_hm1 : r_sy[39:32];
            r_y1 <= w_cly ? w_hm1 : r_sy[39:32] + 8'd1;
            r_fx <= r_sx[31:16];
            r_fy <= r_sy[31:16];
            r_w  <= w_w;
        end
    end

    // Corner indexes and Q0.32 weights of the chosen triangle.
    logic [15:0]   w_base0, w_base1;
    logic [CW-1:0] w_i_lt, w_i_mid, w_i_rb;
    logic          w_lower;
    logic [16:0]   w_ofx, w_ofy;
    logic [33:0]   w_p_ofx_ofy, w_p_fx_ofy, w_p_ofx_fy, w_p_fx_fy;
    logic [32:0]   w_wt_lt, w_wt_mid, w_wt_rb;
    logic [CW-1:0] r_i_lt, r_i_mid, r_i_rb;
    logic          r_ok_lt, r_ok_mid, r_ok_rb;
    logic [32:0]   r_wt_lt, r_wt_mid, r_wt_rb;

    assign w_base0 = r_y0 * r_w;
    assign w_base1 = r_y1 * r_w;
    assign w_lower = r_fx < r_fy;
    assign w_i_lt  = CW'(w_base0) + CW'(r_x0);
    assign w_i_mid = w_lower ? CW'(w_base1) + CW'(r_x0) : CW'(w_base0) + CW'(r_x1);
    assign w_i_rb  = CW'(w_base1) + CW'(r_x1);

    assign w_ofx       = 17'd65536 - {1'b0, r_fx};
    assign w_ofy       = 17'd65536 - {1'b0, r_fy};
    assign w_p_ofx_ofy = w_ofx * w_ofy;
    assign w_p_fx_ofy  = r_fx * w_ofy;
    assign w_p_ofx_fy  = w_ofx * r_fy;
    assign w_p_fx_fy   = r_fx * r_fy;

    always_comb begin
        if (w_lower) begin
            w_wt_lt  = {w_ofy, 16'd0};
            w_wt_mid = w_p_ofx_fy[32:0];
            w_wt_rb  = w_p_fx_fy[32:0];
        end else begin
            w_wt_lt  = w_p_ofx_ofy[32:0];
            w_wt_mid = w_p_fx_ofy[32:0];
            w_wt_rb  = {1'b0, r_fy, 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_ld) begin
            r_i_lt   <= w_i_lt;
            r_i_mid  <= w_i_mid;
            r_i_rb   <= w_i_rb;
            r_ok_lt  <= w_i_lt < CELLS;
            r_ok_mid <= w_i_mid < CELLS;
            r_ok_rb  <= w_i_rb < CELLS;
            r_wt_lt  <= w_wt_lt;
            r_wt_mid <= w_wt_mid;
            r_wt_rb  <= w_wt_rb;
        end
    end

    // Height grid.
    logic [CW-1:0] w_widx, w_ridx;
    logic          w_we;
    logic [31:0]   w_rdata;

    assign w_widx = CW'(i_cell_index);
    assign w_we   = i_cmd.w_en && (w_widx < CELLS);

    always_comb begin
        case (i_cmd.rd_sel)
            C_LT:    w_ridx = r_i_lt;
            C_MID:   w_ridx = r_i_mid;
            default: w_ridx = r_i_rb;
        endcase
    end

    hmas_ram #(
        .WIDTH (32),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_widx[AW-1:0]),
        .i_wdata (i_cell_height),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_ridx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Weighted sum, one corner per cycle.
    logic [32:0]        w_wt;
    logic               w_ok;
    logic [31:0]        w_h_sel;
    logic signed [65:0] w_prod;
    logic [63:0]        r_prod, r_acc, w_round;

    always_comb begin
        case (i_cmd.mul_sel)
            C_LT: begin
                w_wt = r_wt_lt;
                w_ok = r_ok_lt;
            end
            C_MID: begin
                w_wt = r_wt_mid;
                w_ok = r_ok_mid;
            end
            default: begin
                w_wt = r_wt_rb;
                w_ok = r_ok_rb;
            end
        endcase
    end

    // A corner beyond the grid contributes a zero height.
    assign w_h_sel = w_ok ? w_rdata : 32'd0;
    assign w_prod  = $signed(w_h_sel) * $signed({1'b0, w_wt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Round half up from Q16.48 back to Q16.16.
    assign w_round = r_acc + 64'h0000_0000_8000_0000;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_data <= w_round[63:32];
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_ready;
    assign o_valid         = r_out_valid;
    assign o_altitude      = r_out_data;

endmodule

FILE: sv/heightmap_altitude_sampler_top.sv
`timescale 1ns / 1ps
// Terrain altitude sampler on a stored grid of signed Q16.16 heights.
// Input channel (i_valid / o_ready) carries one item per transfer. A write
// item (opcode 0) stores i_cell_height at flat index i_cell_index; it gives
// no result and leaves the block ready, so writes can stream back to back. A query
// item (opcode 1) gives a world point and yields one altitude on the output
// channel (o_valid / i_ready).
// A query passes through its steps in order: x and then y on the shared 32x32
// scaling multiplier, finding the cell, indexes and weights, three reads
// through the single grid read port, multiply-accumulate and rounding.
// When the rounded result is loaded, o_valid rises, and o_ready returns in
// the same cycle.
// The result sits in an output register, so the next item is taken while it
// waits. When the receiver stalls with a result still pending, a finished
// query holds in its last step until the output register frees up.
// Reset is synchronous and active low. It sets the configuration registers
// to their defaults (128 by 128 cells, origin zero, unit scale) and empties
// the output register. The grid is not cleared, and a query must only touch
// cells that have been written. The user must write configuration through the
// APB port only while idle, not enforced by the block; pready is tied high.

module heightmap_altitude_sampler_top #(
    parameter int GRID_CELLS = hmas_pkg::GRID_CELLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [13:0] i_cell_index,
    input  logic [31:0] i_cell_height,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_altitude
);

    import hmas_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Configuration register file behind the APB port.
    hmas_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller sequences each query through the datapath steps.
    hmas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // The datapath holds the grid memory, the arithmetic and the output register.
    hmas_dp #(
        .GRID_CELLS (GRID_CELLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .i_cell_index  (i_cell_index),
        .i_cell_height (i_cell_height),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_ready       (i_ready),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_altitude    (o_altitude)
    );

endmodule

FILE: sv/hmas_chk.sv
`timescale 1ns / 1ps
`include "heightmap_altitude_sampler_top_assert.svh"

module hmas_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_opcode,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_altitude
);

    import hmas_pkg::*;

    // A stalled result keeps its value.
    `HMAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_altitude))

    // A query keeps the block busy in the following cycle.
    `HMAS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n,
        i_valid && o_ready && (i_opcode == OP_QUERY), !o_ready)

    // A write leaves the block ready for the next item.
    `HMAS_ASSERT_NEXT(a_write_ready, i_clk, i_rst_n,
        i_valid && o_ready && (i_opcode == OP_WRITE), o_ready)

    // With no result pending, none can follow a query in the very next cycle.
    `HMAS_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n,
        i_valid && o_ready && (i_opcode == OP_QUERY) && !o_valid, !o_valid)

endmodule

bind heightmap_altitude_sampler_top hmas_chk u_hmas_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_opcode   (i_opcode),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_altitude (o_altitude)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import hmas_pkg::*;

    localparam int GRID_CELLS = GRID_CELLS_DEF;
    // Address of a register slot that the block does not implement.
    localparam logic [4:0] UNUSED_REG_ADDR = 5'd20;
    localparam logic [31:0] HEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] HEIGHT_MIN = 32'h8000_0000;
    localparam longint INT32_MAX = 64'sd2147483647;
    localparam longint INT32_MIN = -64'sd2147483648;
    localparam longint HALF_LSB = 64'sd2147483648;
    localparam longint Q16_ONE = 64'sd65536;
    // Margin that covers a query inside the block plus the output register.
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        TOP_LEFT,
        TOP_RIGHT,
        BOTTOM_LEFT,
        BOTTOM_RIGHT
    } t_corner_pos;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] altitude;
    } t_altitude_due;

    // Mirror of the height grid and the registers, plus the altitudes still owed.
    class t_altitude_scoreboard;
        logic [31:0] grid [GRID_CELLS];
        logic [7:0] grid_width;
        logic [7:0] grid_height;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] cell_scale;
        t_altitude_due altitudes_due [$];
        int errors;
        int writes_seen;
        int queries_seen;
        int results_seen;

        function new();
            grid_width = RST_GRID_WIDTH;
            grid_height = RST_GRID_HEIGHT;
            origin_x = RST_ORIGIN_X;
            origin_y = RST_ORIGIN_Y;
            cell_scale = RST_CELL_SCALE;
            errors = 0;
            writes_seen = 0;
            queries_seen = 0;
            results_seen = 0;
        endfunction

        function void set_reg(t_reg_idx r, logic [31:0] value);
            case (r)
                REG_GRID_WIDTH: grid_width = value[7:0];
                REG_GRID_HEIGHT: grid_height = value[7:0];
                REG_ORIGIN_X: origin_x = value;
                REG_ORIGIN_Y: origin_y = value;
                REG_CELL_SCALE: cell_scale = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(t_reg_idx r);
            case (r)
                REG_GRID_WIDTH: return {24'h0, grid_width};
                REG_GRID_HEIGHT: return {24'h0, grid_height};
                REG_ORIGIN_X: return origin_x;
                REG_ORIGIN_Y: return origin_y;
                default: return cell_scale;
            endcase
        endfunction

        function int pending();
            return altitudes_due.size();
        endfunction

        // World coordinate to cell number and Q0.16 fraction. The offset from the
        // origin is clamped at zero, then scaled into Q32.32 and floored.
        function void locate(logic [31:0] pt, logic [31:0] org,
                             output logic [31:0] cell_num, output logic [15:0] frac);
            longint d;
            logic [63:0] s;
            d = longint'($signed(pt)) - longint'($signed(org));
            if (d < 0) begin
                d = 0;
            end
            s = 64'(d) * {32'h0, cell_scale};
            cell_num = s[63:32];
            frac = s[31:16];
        endfunction

        // Flat indexes of the four corners around a point. On the far edge both
        // neighbours collapse onto the last column or row.
        function void find_corners(logic [31:0] px, logic [31:0] py, output longint idx [4],
                                   output longint fx, output longint fy);
            logic [31:0] col;
            logic [31:0] row;
            logic [15:0] fxb;
            logic [15:0] fyb;
            longint w;
            longint h;
            longint x;
            longint y;
            longint x2;
            longint y2;
            w = (grid_width == 8'd0) ? 64'sd1 : longint'(grid_width);
            h = (grid_height == 8'd0) ? 64'sd1 : longint'(grid_height);
            locate(px, origin_x, col, fxb);
            locate(py, origin_y, row, fyb);
            x = longint'(col);
            y = longint'(row);
            x2 = x + 1;
            y2 = y + 1;
            if (x2 >= w) begin
                x = w - 1;
                x2 = w - 1;
            end
            if (y2 >= h) begin
                y = h - 1;
                y2 = h - 1;
            end
            idx[TOP_LEFT] = y * w + x;
            idx[TOP_RIGHT] = y * w + x2;
            idx[BOTTOM_LEFT] = y2 * w + x;
            idx[BOTTOM_RIGHT] = y2 * w + x2;
            fx = longint'(fxb);
            fy = longint'(fyb);
        endfunction

        // Triangle blend of the corner heights. The weights are exact in Q0.32,
        // so the 64-bit sum is exact and is rounded half up back to Q16.16.
        function logic [31:0] predict_altitude(logic [31:0] px, logic [31:0] py);
            longint idx [4];
            longint hgt [4];
            longint fx;
            longint fy;
            longint sum;
            longint rounded;
            int c;
            find_corners(px, py, idx, fx, fy);
            for (c = 0; c < 4; c++) begin
                // Corners past the end of the memory read as zero.
                if (idx[c] >= GRID_CELLS) begin
                    hgt[c] = 0;
                end else begin
                    hgt[c] = longint'($signed(grid[idx[c]]));
                end
            end
            if (fx < fy) begin
                sum = hgt[TOP_LEFT] * ((Q16_ONE - fy) * Q16_ONE)
                    + hgt[BOTTOM_LEFT] * ((Q16_ONE - fx) * fy)
                    + hgt[BOTTOM_RIGHT] * (fx * fy);
            end else begin
                sum = hgt[TOP_LEFT] * ((Q16_ONE - fx) * (Q16_ONE - fy))
                    + hgt[TOP_RIGHT] * (fx * (Q16_ONE - fy))
                    + hgt[BOTTOM_RIGHT] * (fy * Q16_ONE);
            end
            rounded = (sum + HALF_LSB) >>> 32;
            return 32'(rounded);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task note_input(t_op op, logic [13:0] idx, logic [31:0] height,
                        logic [31:0] px, logic [31:0] py);
            t_altitude_due due;
            if (op == OP_WRITE) begin
                if (int'(idx) < GRID_CELLS) begin
                    grid[idx] = height;
                end
                writes_seen++;
            end else begin
                due.px = px;
                due.py = py;
                due.altitude = predict_altitude(px, py);
                altitudes_due.push_back(due);
                queries_seen++;
            end
        endtask

        task check_result(logic [31:0] got);
            t_altitude_due due;
            if (altitudes_due.size() == 0) begin
                report_mismatch($sformatf("altitude %h with no query outstanding", got));
            end else begin
                due = altitudes_due.pop_front();
                results_seen++;
                if (got !== due.altitude) begin
                    report_mismatch($sformatf("query (%h, %h): altitude %h, expected %h",
                                              due.px, due.py, got, due.altitude));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic i_valid;
    logic o_ready;
    logic i_opcode;
    logic [13:0] i_cell_index;
    logic [31:0] i_cell_height;
    logic [31:0] i_point_x;
    logic [31:0] i_point_y;
    logic o_valid;
    logic i_ready;
    logic [31:0] o_altitude;

    t_altitude_scoreboard sb;
    bit written [GRID_CELLS];
    bit calm;
    int items_sent;
    int settings_run;
    int span_x;
    int span_y;
    int win_x;
    int win_y;
    int stall_left;
    int quiet_cycles;

    heightmap_altitude_sampler_top #(
        .GRID_CELLS(GRID_CELLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_cell_index(i_cell_index),
        .i_cell_height(i_cell_height),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_altitude(o_altitude)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle lengths: mostly none, often a few cycles, now and then a long pause.
    function automatic int gap_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return int'($urandom_range(1, 3));
        end
        if (r < 97) begin
            return int'($urandom_range(4, 12));
        end
        return int'($urandom_range(20, 40));
    endfunction

    function automatic logic [31:0] random_height();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 8) begin
            return HEIGHT_MAX;
        end
        if (r < 16) begin
            return HEIGHT_MIN;
        end
        if (r < 20) begin
            return 32'h0;
        end
        return 32'($urandom);
    endfunction

    // A world coordinate for one axis. Most land in a small window of cells so
    // that corners get reused; the rest fall anywhere on the grid, just below
    // the origin, or anywhere at all.
    function automatic logic [31:0] pick_coord(logic [31:0] org, int span, int win);
        int r;
        logic [63:0] target;
        logic [63:0] d;
        longint offset;
        longint p;
        r = int'($urandom_range(0, 99));
        if (r >= 95) begin
            return 32'($urandom);
        end
        if (r >= 90) begin
            offset = -longint'($urandom_range(1, 1 << 20));
        end else begin
            if (r < 80) begin
                target = {32'(win + int'($urandom_range(0, 3))), 32'($urandom)};
            end else begin
                target = {32'($urandom_range(0, span)), 32'($urandom)};
            end
            if (sb.cell_scale == 32'h0) begin
                d = {32'h0, 32'($urandom)};
            end else begin
                d = target / {32'h0, sb.cell_scale};
            end
            if (d > 64'hFFFF_FFFF) begin
                d = 64'hFFFF_FFFF;
            end
            offset = longint'(d);
        end
        p = longint'($signed(org)) + offset;
        if (p > INT32_MAX) begin
            p = INT32_MAX;
        end
        if (p < INT32_MIN) begin
            p = INT32_MIN;
        end
        return 32'(p);
    endfunction

    // Both sides are sampled right at the rising edge, before anything the
    // edge itself schedules, so the scoreboard sees the transfer values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_input(t_op'(i_opcode), i_cell_index, i_cell_height,
                              i_point_x, i_point_y);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_altitude);
            end
        end
    end

    // Receiver back-pressure. After every stall i_ready goes high again before the next one.
    always @(posedge i_clk) begin
        int n;
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!i_ready) begin
            i_ready <= 1'b1;
        end else begin
            n = gap_len();
            if (n > 0) begin
                i_ready <= 1'b0;
                stall_left = n - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d altitudes outstanding.",
                         quiet_cycles, sb.pending());
                $display("heightmap_altitude_sampler_top regression: fail");
                $finish;
            end
        end
    end

    task automatic apb_access(logic write, logic [4:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx r, logic [31:0] value);
        logic [31:0] unused_rd;
        apb_access(1'b1, {r, 2'b00}, value, unused_rd);
        sb.set_reg(r, value);
    endtask

    task automatic verify_registers();
        t_reg_idx r;
        logic [31:0] rd;
        logic [31:0] mask;
        r = r.first();
        repeat (r.num()) begin
            apb_access(1'b0, {r, 2'b00}, 32'h0, rd);
            mask = (r == REG_GRID_WIDTH || r == REG_GRID_HEIGHT) ? 32'h0000_00FF : 32'hFFFF_FFFF;
            if (((rd ^ sb.reg_value(r)) & mask) !== 32'h0) begin
                sb.report_mismatch($sformatf("register %s reads %h, expected %h",
                                             r.name(), rd, sb.reg_value(r)));
            end
            r = r.next();
        end
    endtask

    // One input transfer. Valid is only dropped when a gap is actually taken,
    // so back-to-back items keep it high.
    task automatic send_item(t_op op, logic [13:0] idx, logic [31:0] height,
                             logic [31:0] px, logic [31:0] py);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_cell_index <= idx;
        i_cell_height <= height;
        i_point_x <= px;
        i_point_y <= py;
        if (op == OP_WRITE) begin
            written[idx] = 1'b1;
        end
        do @(posedge i_clk); while (o_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic write_cell(logic [13:0] idx, logic [31:0] height);
        send_item(OP_WRITE, idx, height, 32'($urandom), 32'($urandom));
    endtask

    // Any corner the query will read that has never been written gets a height
    // first, since the grid holds garbage until then.
    task automatic query(logic [31:0] px, logic [31:0] py);
        longint idx [4];
        longint fx;
        longint fy;
        int c;
        sb.find_corners(px, py, idx, fx, fy);
        for (c = 0; c < 4; c++) begin
            if (idx[c] < GRID_CELLS && !written[idx[c]]) begin
                write_cell(14'(idx[c]), random_height());
            end
        end
        send_item(OP_QUERY, 14'($urandom), 32'($urandom), px, py);
    endtask

    // Wait for every owed altitude, then let an in-flight write drain.
    task automatic settle();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_items(int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 15) begin
                write_cell(14'($urandom), random_height());
            end else begin
                query(pick_coord(sb.origin_x, span_x, win_x), pick_coord(sb.origin_y, span_y, win_y));
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [7:0] w, logic [7:0] h, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] scale, int n, bit poke_unused);
        logic [31:0] unused_rd;
        settle();
        reg_write(REG_GRID_WIDTH, {24'h0, w});
        reg_write(REG_GRID_HEIGHT, {24'h0, h});
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_CELL_SCALE, scale);
        if (poke_unused) begin
            // A write to a hole in the map must leave every register alone.
            apb_access(1'b1, UNUSED_REG_ADDR, 32'($urandom), unused_rd);
        end
        verify_registers();
        settings_run++;
        span_x = (w == 8'd0) ? 1 : int'(w);
        span_y = (h == 8'd0) ? 1 : int'(h);
        win_x = int'($urandom_range(0, span_x - 1));
        win_y = int'($urandom_range(0, span_y - 1));
        random_items(n);
    endtask

    initial begin
        int k;
        sb = new();
        calm = 1'b0;
        items_sent = 0;
        settings_run = 1;
        stall_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'h0;
        pwdata = 32'h0;
        i_valid = 1'b0;
        i_opcode = OP_WRITE;
        i_cell_index = 14'h0;
        i_cell_height = 32'h0;
        i_point_x = 32'h0;
        i_point_y = 32'h0;
        i_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then a directed pass on the default 128 x 128 unit grid
        // where a coordinate is simply cell.fraction in Q16.16.
        verify_registers();
        span_x = 128;
        span_y = 128;
        write_cell(14'd0, HEIGHT_MAX);
        write_cell(14'd1, HEIGHT_MIN);
        write_cell(14'd128, HEIGHT_MIN);
        write_cell(14'd129, HEIGHT_MAX);
        query(32'h0000_0000, 32'h0000_0000);
        query(32'h0000_8000, 32'h0000_4000);
        query(32'h0000_4000, 32'h0000_C000);
        query(32'h0000_FFFF, 32'h0000_FFFF);
        query(32'h0000_8000, 32'h0000_8000);
        // Far column and far row: neighbours clamp to the last cell.
        query({16'd127, 16'h8000}, {16'd127, 16'h1234});
        query({16'd126, 16'hFFFF}, {16'd5, 16'h0001});
        // Points below the origin clamp to zero; huge points clamp to the edge.
        query(32'h8000_0000, 32'hFFFF_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_cell(14'h3FFF, 32'($urandom));
        i_valid <= 1'b0;

        // Smallest grid, then size registers of zero, which act as one.
        run_phase(8'd1, 8'd1, 32'h0001_8000, 32'hFFFE_0000, 32'd65536, 80, 1'b0);
        run_phase(8'd0, 8'd0, 32'h0, 32'h0, 32'd131072, 60, 1'b1);
        // Sizes past the documented range; corners past the memory read as zero.
        // This phase runs with no idling on either side.
        calm = 1'b1;
        run_phase(8'd255, 8'd255, 32'h0, 32'h0, 32'd65536, 100, 1'b0);
        calm = 1'b0;
        // Extreme origins with the smallest scale, then a scale of zero, which
        // pins every query to the first cell.
        run_phase(8'd128, 8'd128, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 60, 1'b0);
        run_phase(8'd128, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 60, 1'b0);
        run_phase(8'd1, 8'd128, 32'($urandom), 32'($urandom), 32'hFFFF_FFFF, 80, 1'b1);
        for (k = 0; k < 4; k++) begin
            calm = (k == 2);
            run_phase(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
                      ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                                  : 32'($signed(24'($urandom))),
                      ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                                  : 32'($signed(24'($urandom))),
                      ($urandom_range(0, 4) == 0) ? 32'($urandom)
                                                  : 32'($urandom_range(1 << 12, 1 << 20)),
                      120, k == 1);
        end
        calm = 1'b0;
        settle();

        $display("Ran %0d grid writes and %0d altitude queries over %0d register settings.",
                 sb.writes_seen, sb.queries_seen, settings_run);
        $display("Compared %0d altitudes; %0d mismatches found.", sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("heightmap_altitude_sampler_top regression: pass");
        end else begin
            $display("heightmap_altitude_sampler_top regression: fail");
        end
        $finish;
    end

endmodule
